>>> design/fpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the fixed-point atan2 pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int unsigned QuoBits = 31;   // a = lo*2^30/hi lies in 0..2^30

   localparam logic signed [31:0] Coef0 = 32'sd26670445;
   localparam logic signed [31:0] Coef1 = 32'sd200557900;
   localparam logic signed [31:0] Coef2 = -32'sd101043000;
   localparam logic signed [31:0] Coef3 = -32'sd356654600;
   localparam logic signed [31:0] RadToBrad = 32'sd21361559;

   localparam logic signed [15:0] QuarterTurn = 16'sd8192;
   localparam logic signed [15:0] HalfTurn    = 16'sd16384;

   // Octant and sign information that rides along with each word.
   typedef struct packed {
      logic steep;
      logic x_neg;
      logic y_neg;
      logic origin;
   } side_type;

endpackage
`default_nettype wire

>>> design/fixed_point_atan2_brads.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_atan2_brads
// Pipelined atan2 of a signed (y, x) pair, result in brads (32768 per turn).
// ----------------------------------------------------------------------------
// One word enters per cycle. One stage forms the magnitudes, 31 stages of the
// restoring divider each settle one bit of the Q30 ratio, and seven stages
// evaluate the polynomial, scale and fold the angle, the last being the output
// register. The whole pipeline holds while a result waits on rsp_tready.
// The origin gives 0 and an input of -2^31 is treated as -2^31+1.
module fixed_point_atan2_brads (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,    // y_value [31:0], x_value [63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata     // angle_brads [15:0]
);
   logic advance;
   logic signed [31:0] y_sat, x_sat;
   logic [30:0] ay, ax;
   fpa_pkg::side_type side_in, side_ff, div_side;
   logic [30:0] lo_ff, hi_ff;
   logic valid_ff, div_valid;
   logic [fpa_pkg::QuoBits-1:0] div_quo;
   logic signed [15:0] brad;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      y_sat = (req_tdata[31:0] == 32'h8000_0000) ? 32'sh8000_0001 : $signed(req_tdata[31:0]);
      x_sat = (req_tdata[63:32] == 32'h8000_0000) ? 32'sh8000_0001 : $signed(req_tdata[63:32]);
      ay = y_sat[31] ? 31'(-y_sat) : y_sat[30:0];
      ax = x_sat[31] ? 31'(-x_sat) : x_sat[30:0];
      side_in.steep  = ay > ax;
      side_in.x_neg  = x_sat[31];
      side_in.y_neg  = y_sat[31];
      side_in.origin = (ay == '0) && (ax == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_tvalid;
      end
   end

   // The origin divides by one so the divider never sees a zero divisor.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= side_in;
         hi_ff   <= side_in.origin ? 31'd1 : (side_in.steep ? ay : ax);
         lo_ff   <= side_in.steep ? ax : ay;
      end
   end

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (valid_ff),
      .in_lo     (lo_ff),
      .in_hi     (hi_ff),
      .in_side   (side_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   fpa_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_a      (div_quo),
      .in_side   (div_side),
      .out_valid (rsp_tvalid),
      .out_brad  (brad)
   );

   assign rsp_tdata = brad;

   // The ratio never exceeds one in Q30.
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> div_quo <= 31'h4000_0000)
      else $error("divider quotient above one");

   // The angle stays within a half turn either way.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (brad <= 16'sd16384) && (brad >= -16'sd16384))
      else $error("angle out of range");

   // A stalled result holds the whole pipeline, including the input side.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && (valid_ff == $past(valid_ff)))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

>>> design/fpa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div
// Restoring divider, one quotient bit per register stage: a = lo*2^30 / hi.
// ----------------------------------------------------------------------------
module fpa_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire logic [30:0]                in_lo,
   input  wire logic [30:0]                in_hi,
   input  wire fpa_pkg::side_type          in_side,
   output logic                            out_valid,
   output logic [fpa_pkg::QuoBits-1:0]     out_quo,
   output fpa_pkg::side_type               out_side
);
   localparam int unsigned N = fpa_pkg::QuoBits;

   logic [30:0]     rem_ff  [N];
   logic [30:0]     hi_ff   [N];
   logic [N-1:0]    quo_ff  [N];
   fpa_pkg::side_type side_ff [N];
   logic [N-1:0]    vld_ff;

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [31:0]   trial;
      logic [32:0]   diff;
      logic [30:0]   hi_src;
      logic [N-1:0]  quo_src;
      fpa_pkg::side_type side_src;
      logic          vld_src;

      // The first step compares lo itself; later steps shift in a zero bit.
      if (k == 0) begin : g_first
         assign trial    = {1'b0, in_lo};
         assign hi_src   = in_hi;
         assign quo_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign trial    = {rem_ff[k-1], 1'b0};
         assign hi_src   = hi_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      assign diff = {1'b0, trial} - {2'b00, hi_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= diff[32] ? trial[30:0] : diff[30:0];
            quo_ff[k]  <= {quo_src[N-2:0], ~diff[32]};
            hi_ff[k]   <= hi_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule
`default_nettype wire

>>> design/fpa_poly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_poly
// Odd minimax polynomial in Q30, brad scaling and octant fold, one multiply
// level per register stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module fpa_poly (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire logic [fpa_pkg::QuoBits-1:0] in_a,
   input  wire fpa_pkg::side_type          in_side,
   output logic                            out_valid,
   output logic signed [15:0]              out_brad
);
   localparam int unsigned Stages = 7;

   logic [Stages-1:0]  vld_ff;
   fpa_pkg::side_type  side_ff [Stages-1];
   logic signed [31:0] a_ff [Stages-3];

   logic signed [31:0] s1_ff, s2_ff, s3_ff, c2_ff, c3_ff, c4_ff, q2_ff;
   logic signed [31:0] r1_ff, t1_ff, r2_ff, r3_ff;
   logic signed [15:0] b_ff, out_ff;

   logic signed [31:0] a_in;
   logic signed [63:0] p_ss, p_sa, p_qq, p_c0, p_c2, p_r1, p_r2, p_rb;
   logic signed [15:0] fold_a, fold_b, fold_c, out_in;

   assign a_in = $signed({1'b0, in_a});

   assign p_ss = a_in * a_in;
   assign p_sa = s1_ff * a_ff[0];
   assign p_qq = s1_ff * s1_ff;
   assign p_c0 = fpa_pkg::Coef0 * q2_ff;
   assign p_c2 = fpa_pkg::Coef2 * q2_ff;
   assign p_r1 = r1_ff * s3_ff;
   assign p_r2 = r2_ff * c4_ff;
   assign p_rb = r3_ff * fpa_pkg::RadToBrad;

   // Octant fold, then mirror into the left half, then negate for y below 0.
   always_comb begin
      fold_a = side_ff[5].steep ? fpa_pkg::QuarterTurn - b_ff : b_ff;
      fold_b = side_ff[5].x_neg ? fpa_pkg::HalfTurn - fold_a : fold_a;
      fold_c = side_ff[5].y_neg ? -fold_b : fold_b;
      out_in = side_ff[5].origin ? 16'sd0 : fold_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < Stages - 1; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         a_ff[0] <= a_in;
         for (int i = 1; i < Stages - 3; i++) begin
            a_ff[i] <= a_ff[i-1];
         end
         // Stage 1: s = a*a
         s1_ff <= p_ss[61:30];
         // Stage 2: c = s*a, q = s*s
         c2_ff <= p_sa[61:30];
         q2_ff <= p_qq[61:30];
         s2_ff <= s1_ff;
         // Stage 3: inner terms
         r1_ff <= p_c0[61:30] + fpa_pkg::Coef1;
         t1_ff <= p_c2[61:30] + fpa_pkg::Coef3;
         s3_ff <= s2_ff;
         c3_ff <= c2_ff;
         // Stage 4
         r2_ff <= p_r1[61:30] + t1_ff;
         c4_ff <= c3_ff;
         // Stage 5
         r3_ff <= p_r2[61:30] + a_ff[3];
         // Stage 6: both floor shifts merge into one shift of 42
         b_ff  <= p_rb[57:42];
         // Stage 7: output register
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign out_brad  = out_ff;

endmodule
`default_nettype wire
